FILE: hdl/huffman_tree_decoder_macros.svh
// assertion helpers used by the checker file
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HUFD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HUFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hufd_pkg.sv
`timescale 1ns / 1ps

package hufd_pkg;

   localparam int NODE_COUNT_DEF = 512;
   localparam int CHILD_W        = 9;
   localparam int SYM_W          = 8;
   localparam int BYTE_BITS      = 8;
   localparam int COUNT_W        = 4;

   localparam logic KIND_NODE = 1'b0;
   localparam logic KIND_CODE = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [CHILD_W-1:0] node_index;
      logic [CHILD_W-1:0] left_child;
      logic [CHILD_W-1:0] right_child;
      logic [SYM_W-1:0]   leaf_symbol;
      logic [SYM_W-1:0]   code_byte;
      logic [COUNT_W-1:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [CHILD_W-1:0] left;
      logic [CHILD_W-1:0] right;
      logic [SYM_W-1:0]   symbol;
   } node_type;

endpackage

FILE: hdl/hufd_node_mem.sv
`timescale 1ns / 1ps

module hufd_node_mem #(
   parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF,
   localparam int AW = $clog2(NODE_COUNT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  hufd_pkg::node_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output hufd_pkg::node_type rd_data
);

   hufd_pkg::node_type node_mem_ff [NODE_COUNT];
   hufd_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/hufd_rsp_stage.sv
`timescale 1ns / 1ps

module hufd_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  hufd_pkg::rsp_type push_data,
   output logic              push_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hufd_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   hufd_pkg::rsp_type data_ff;
   hufd_pkg::rsp_type data_in;

   assign push_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push_valid) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: hdl/hufd_walker.sv
`timescale 1ns / 1ps

module hufd_walker #(
   parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF,
   localparam int AW = $clog2(NODE_COUNT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  hufd_pkg::req_type  req_data,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output hufd_pkg::node_type wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  hufd_pkg::node_type rd_data,
   output logic               push_valid,
   output hufd_pkg::rsp_type  push_data,
   input  logic               push_free
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type                          state_ff, state_in;
   logic [hufd_pkg::BYTE_BITS-1:0]     byte_ff, byte_in;
   logic [hufd_pkg::COUNT_W-1:0]       bits_ff, bits_in;
   logic                               pend_ff, pend_in;
   logic [AW-1:0]                      pend_addr_ff, pend_addr_in;
   logic [AW-1:0]                      pos_ff, pos_in;
   hufd_pkg::node_type                 cur_ff, cur_in;
   hufd_pkg::node_type                 root_ff, root_in;
   logic                               hold_valid_ff, hold_valid_in;
   logic [hufd_pkg::SYM_W-1:0]         hold_sym_ff, hold_sym_in;

   logic                               accept;
   logic                               leaf;
   logic                               stall;
   hufd_pkg::node_type                 eff;
   logic [AW-1:0]                      eff_pos;
   logic [hufd_pkg::CHILD_W-1:0]       nxt;
   hufd_pkg::node_type                 new_node;

   function automatic logic in_range(input logic [hufd_pkg::CHILD_W-1:0] idx);
      return 32'(idx) < NODE_COUNT;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign leaf      = (rd_data.left == '0) && (rd_data.right == '0);
   // a leaf needs the hold slot, which can only empty into a free output
   assign stall     = pend_ff && leaf && hold_valid_ff && !push_free;

   assign new_node.left   = req_data.left_child;
   assign new_node.right  = req_data.right_child;
   assign new_node.symbol = req_data.leaf_symbol;

   assign wr_addr = AW'(req_data.node_index);
   assign wr_data = new_node;

   always_comb begin
      state_in      = state_ff;
      byte_in       = byte_ff;
      bits_in       = bits_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      hold_valid_in = hold_valid_ff;
      hold_sym_in   = hold_sym_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = pend_addr_ff;
      push_valid    = 1'b0;
      push_data     = '0;
      eff           = cur_ff;
      eff_pos       = pos_ff;
      nxt           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == hufd_pkg::KIND_NODE) begin
                  if (in_range(req_data.node_index)) begin
                     wr_en = 1'b1;
                     // keep the cached root and current node coherent with the store
                     if (req_data.node_index == '0) begin
                        root_in = new_node;
                     end
                     if (AW'(req_data.node_index) == pos_ff) begin
                        cur_in = new_node;
                     end
                  end
               end else begin
                  byte_in  = req_data.code_byte;
                  bits_in  = (req_data.bit_count > hufd_pkg::COUNT_W'(hufd_pkg::BYTE_BITS)) ?
                             hufd_pkg::COUNT_W'(hufd_pkg::BYTE_BITS) : req_data.bit_count;
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (!stall) begin
               if (pend_ff) begin
                  if (leaf) begin
                     eff     = root_ff;
                     eff_pos = '0;
                     if (hold_valid_ff) begin
                        push_valid       = 1'b1;
                        push_data.symbol = hold_sym_ff;
                        push_data.last   = 1'b0;
                     end
                     hold_valid_in = 1'b1;
                     hold_sym_in   = rd_data.symbol;
                  end else begin
                     eff     = rd_data;
                     eff_pos = pend_addr_ff;
                  end
               end
               cur_in  = eff;
               pos_in  = eff_pos;
               pend_in = 1'b0;

               if (bits_ff != '0) begin
                  nxt     = byte_ff[hufd_pkg::BYTE_BITS-1] ? eff.right : eff.left;
                  byte_in = byte_ff << 1;
                  bits_in = bits_ff - hufd_pkg::COUNT_W'(1);
                  if ((nxt != '0) && in_range(nxt)) begin
                     rd_en        = 1'b1;
                     rd_addr      = AW'(nxt);
                     pend_in      = 1'b1;
                     pend_addr_in = AW'(nxt);
                  end else begin
                     // absent child: back to the root, nothing emitted
                     cur_in = root_ff;
                     pos_in = '0;
                  end
               end else if (!pend_ff) begin
                  // byte finished: the held symbol is its last one
                  if (hold_valid_ff) begin
                     if (push_free) begin
                        push_valid       = 1'b1;
                        push_data.symbol = hold_sym_ff;
                        push_data.last   = 1'b1;
                        hold_valid_in    = 1'b0;
                        state_in         = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         pos_ff        <= '0;
         hold_valid_ff <= 1'b0;
         bits_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         pos_ff        <= pos_in;
         hold_valid_ff <= hold_valid_in;
         bits_ff       <= bits_in;
      end
      byte_ff      <= byte_in;
      pend_addr_ff <= pend_addr_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      hold_sym_ff  <= hold_sym_in;
   end

endmodule

FILE: hdl/huffman_tree_decoder.sv
`timescale 1ns / 1ps
// channel   handshake               payload             role
// req       req_valid / req_ready   req_data  (req_type) node writes and code bytes
// rsp       rsp_valid / rsp_ready   rsp_data  (rsp_type) decoded symbols, last per byte
//
// a node write leaves req_ready high; after a code byte req_ready stays low while its
// bits are walked, with at most one dependent node memory read per bit, and while the
// walk is stalled on rsp_ready
// the walk stalls when a leaf is found while two symbols already wait for rsp, and at
// the end of a byte while its last symbol cannot enter the output register
// reset clears the walk position to the root and empties the output; the node store
// itself is not cleared, nodes are undefined until written

module huffman_tree_decoder #(
   parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hufd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hufd_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(NODE_COUNT);

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   hufd_pkg::node_type wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   hufd_pkg::node_type rd_data;
   logic               push_valid;
   hufd_pkg::rsp_type  push_data;
   logic               push_free;

   hufd_node_mem #(
      .NODE_COUNT(NODE_COUNT)
   ) u_node_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   hufd_walker #(
      .NODE_COUNT(NODE_COUNT)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_free (push_free)
   );

   hufd_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_free (push_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/hufd_checker.sv
`timescale 1ns / 1ps
`include "huffman_tree_decoder_macros.svh"

module hufd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input hufd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hufd_pkg::rsp_type rsp_data
);

   // a stalled result transaction holds its payload
   `HUFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp payload changed while stalled")

   // a code byte occupies the walker for at least the next cycle
   `HUFD_ASSERT_NEXT(a_byte_busy, clock, reset, req_valid && req_ready && (req_data.kind == hufd_pkg::KIND_CODE), !req_ready, "ready after a code byte transaction")

   // a node write never blocks the next transaction
   `HUFD_ASSERT_NEXT(a_node_ready, clock, reset, req_valid && req_ready && (req_data.kind == hufd_pkg::KIND_NODE), req_ready, "not ready after a node write")

   // results only appear while a byte is being decoded
   `HUFD_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid), !$past(req_ready), "result without a byte in flight")

endmodule

bind huffman_tree_decoder hufd_checker u_hufd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
